### sv/dcp_pkg.sv
package dcp_pkg;

    localparam int POS_W    = 32;
    localparam int IDX_W    = 16;
    localparam int MASS_W   = 24;
    localparam int REST_W   = 31;
    localparam int STIFF_W  = 17;
    localparam int STAT_W   = 2;

    localparam logic [STIFF_W-1:0] K_ONE = 17'h10000;

    localparam logic [STAT_W-1:0] ST_APPLIED    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_MASS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_COINCIDENT = 2'd2;

    // |d| per axis, squares, sum of squares
    localparam int MAG_W    = POS_W + 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int RAD_W    = SQ_W;
    localparam int SQ_STEPS = RAD_W / 2;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int SQ_REM_W = ROOT_W + 2;

    localparam int ERR_W    = ROOT_W + 1;
    localparam int NF_W     = MASS_W + STIFF_W;
    localparam int WSUM_W   = MASS_W + 1;
    localparam int UNIT_SH  = 30;

    // divider parameters, common to all five dividers: unit numerator m << 30, quotient below 2^31
    localparam int DIV_STEPS  = 31;
    localparam int DIV_NUM_W  = MAG_W + UNIT_SH;
    localparam int DIV_DEN_W  = ROOT_W + 2;
    localparam int DIV_HI_PAD = DIV_DEN_W - (DIV_NUM_W - DIV_STEPS);

    localparam int SHARE_W  = STIFF_W;
    localparam int A_W      = ERR_W + SHARE_W;
    localparam int A_LO_W   = 26;
    localparam int A_HI_W   = A_W - A_LO_W;
    localparam int PL_W     = A_LO_W + DIV_STEPS;
    localparam int PH_W     = A_HI_W + DIV_STEPS;
    localparam int FULL_W   = A_W + DIV_STEPS;
    localparam int CORR_SH  = 46;
    localparam int CMAG_W   = FULL_W - CORR_SH;
    localparam int ACC_W    = CMAG_W + 2;

    localparam int PIPE_STAGES = 3 + SQ_STEPS + 1 + DIV_STEPS + 4;

    typedef logic [SQ_W-1:0]      t_sq;
    typedef logic [DIV_NUM_W-1:0] t_div_num;
    typedef logic [DIV_DEN_W-1:0] t_div_den;
    typedef logic [FULL_W-1:0]    t_full;
    typedef logic [ACC_W-1:0]     t_acc;
    typedef logic [A_W-1:0]       t_a;
    typedef logic [ERR_W-1:0]     t_err;

    typedef struct packed {
        logic signed [POS_W-1:0]  first_x;
        logic signed [POS_W-1:0]  first_y;
        logic signed [POS_W-1:0]  first_z;
        logic signed [POS_W-1:0]  second_x;
        logic signed [POS_W-1:0]  second_y;
        logic signed [POS_W-1:0]  second_z;
        logic [MASS_W-1:0]        first_inv_mass;
        logic [MASS_W-1:0]        second_inv_mass;
        logic [REST_W-1:0]        rest_length;
        logic [IDX_W-1:0]         first_index;
        logic [IDX_W-1:0]         second_index;
    } t_in_word;

    typedef struct packed {
        logic signed [POS_W-1:0]  new_first_x;
        logic signed [POS_W-1:0]  new_first_y;
        logic signed [POS_W-1:0]  new_first_z;
        logic signed [POS_W-1:0]  new_second_x;
        logic signed [POS_W-1:0]  new_second_y;
        logic signed [POS_W-1:0]  new_second_z;
        logic [IDX_W-1:0]         out_first_index;
        logic [IDX_W-1:0]         out_second_index;
        logic [STAT_W-1:0]        status;
    } t_out_word;

    typedef struct packed {
        logic [2:0][POS_W-1:0]    p1;
        logic [2:0][POS_W-1:0]    p2;
        logic [IDX_W-1:0]         idx1;
        logic [IDX_W-1:0]         idx2;
        logic [REST_W-1:0]        rest;
        logic [2:0][MAG_W-1:0]    m;
        logic [2:0]               neg;
        logic [STAT_W-1:0]        status;
        logic [NF_W-1:0]          nf1;
        logic [NF_W-1:0]          nf2;
        logic [WSUM_W-1:0]        wsum;
    } t_side;

    function automatic logic [POS_W-1:0] sat32(input logic [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = $signed(v);
        if (s > $signed(t_acc'(32'h7FFFFFFF))) begin
            sat32 = 32'h7FFFFFFF;
        end else if (s < -$signed(t_acc'(33'h080000000))) begin
            sat32 = 32'h80000000;
        end else begin
            sat32 = v[POS_W-1:0];
        end
    endfunction

endpackage

### sv/dcp_div.sv
module dcp_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [dcp_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [dcp_pkg::DIV_DEN_W-1:0]  i_den,
    output logic [dcp_pkg::DIV_STEPS-1:0]  o_quo
);

    logic [dcp_pkg::DIV_DEN_W-1:0] r_rem [dcp_pkg::DIV_STEPS];
    logic [dcp_pkg::DIV_STEPS-1:0] r_lo  [dcp_pkg::DIV_STEPS];
    logic [dcp_pkg::DIV_DEN_W-1:0] r_den [dcp_pkg::DIV_STEPS];

    // lo holds remaining numerator bits on top, quotient bits shifting in below
    genvar j;
    generate
        for (j = 0; j < dcp_pkg::DIV_STEPS; j++) begin : g_step
            logic [dcp_pkg::DIV_DEN_W-1:0] w_rem;
            logic [dcp_pkg::DIV_STEPS-1:0] w_lo;
            logic [dcp_pkg::DIV_DEN_W-1:0] w_den;
            logic [dcp_pkg::DIV_DEN_W:0]   w_t;
            logic [dcp_pkg::DIV_DEN_W:0]   w_d;
            logic                          w_ge;
            logic [dcp_pkg::DIV_DEN_W-1:0] n_rem;
            logic [dcp_pkg::DIV_STEPS-1:0] n_lo;

            if (j == 0) begin : g_first
                assign w_rem = {{dcp_pkg::DIV_HI_PAD{1'b0}},
                                i_num[dcp_pkg::DIV_NUM_W-1:dcp_pkg::DIV_STEPS]};
                assign w_lo  = i_num[dcp_pkg::DIV_STEPS-1:0];
                assign w_den = i_den;
            end else begin : g_next
                assign w_rem = r_rem[j-1];
                assign w_lo  = r_lo[j-1];
                assign w_den = r_den[j-1];
            end

            always_comb begin
                w_t   = {w_rem, w_lo[dcp_pkg::DIV_STEPS-1]};
                w_d   = w_t - {1'b0, w_den};
                w_ge  = (w_t >= {1'b0, w_den});
                n_rem = w_ge ? w_d[dcp_pkg::DIV_DEN_W-1:0] : w_t[dcp_pkg::DIV_DEN_W-1:0];
                n_lo  = {w_lo[dcp_pkg::DIV_STEPS-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= n_rem;
                    r_lo[j]  <= n_lo;
                    r_den[j] <= w_den;
                end
            end
        end
    endgenerate

    assign o_quo = r_lo[dcp_pkg::DIV_STEPS-1];

endmodule

### sv/dcp_sqrt.sv
module dcp_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [dcp_pkg::RAD_W-1:0]     i_rad,
    output logic [dcp_pkg::ROOT_W-1:0]    o_root
);

    logic [dcp_pkg::SQ_REM_W-1:0] r_rem  [dcp_pkg::SQ_STEPS];
    logic [dcp_pkg::ROOT_W-1:0]   r_root [dcp_pkg::SQ_STEPS];
    logic [dcp_pkg::RAD_W-1:0]    r_rad  [dcp_pkg::SQ_STEPS];

    // one result bit per stage, two radicand bits consumed
    genvar j;
    generate
        for (j = 0; j < dcp_pkg::SQ_STEPS; j++) begin : g_step
            logic [dcp_pkg::SQ_REM_W-1:0] w_rem;
            logic [dcp_pkg::ROOT_W-1:0]   w_root;
            logic [dcp_pkg::RAD_W-1:0]    w_rad;
            logic [dcp_pkg::SQ_REM_W+1:0] w_t;
            logic [dcp_pkg::SQ_REM_W+1:0] w_trial;
            logic [dcp_pkg::SQ_REM_W+1:0] w_d;
            logic                         w_ge;

            if (j == 0) begin : g_first
                assign w_rem  = '0;
                assign w_root = '0;
                assign w_rad  = i_rad;
            end else begin : g_next
                assign w_rem  = r_rem[j-1];
                assign w_root = r_root[j-1];
                assign w_rad  = r_rad[j-1];
            end

            always_comb begin
                w_t     = {w_rem, w_rad[dcp_pkg::RAD_W-1 -: 2]};
                w_trial = {1'b0, w_root, 2'b01};
                w_d     = w_t - w_trial;
                w_ge    = (w_t >= w_trial);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j]  <= w_ge ? w_d[dcp_pkg::SQ_REM_W-1:0]
                                      : w_t[dcp_pkg::SQ_REM_W-1:0];
                    r_root[j] <= {w_root[dcp_pkg::ROOT_W-2:0], w_ge};
                    r_rad[j]  <= {w_rad[dcp_pkg::RAD_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_root = r_root[dcp_pkg::SQ_STEPS-1];

endmodule

### sv/distance_constraint_projection.sv
// Distance-constraint projection, one constraint word in and one result word out.
// A word may enter every cycle while the output is not stalled. The pipeline is
// 72 stages deep, most of that depth in the 33-stage square root (one root bit
// per stage) followed by the 31-stage dividers (one quotient bit per stage).
// A stall on the output freezes the whole pipeline. The stiffness register is
// written through i_cfg_we and i_cfg_data; the user must write it only while no
// word is in flight, which the block does not enforce. Values above one act as one.
module distance_constraint_projection (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  dcp_pkg::t_in_word              i_word,
    output logic                           o_valid,
    input  logic                           i_ready,
    output dcp_pkg::t_out_word             o_word,
    input  logic                           i_cfg_we,
    input  logic [dcp_pkg::STIFF_W-1:0]    i_cfg_data
);

    logic [dcp_pkg::STIFF_W-1:0]     r_stiff;
    logic [dcp_pkg::PIPE_STAGES-1:0] r_vld;
    logic                            w_en;

    assign w_en    = !r_vld[dcp_pkg::PIPE_STAGES-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[dcp_pkg::PIPE_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= dcp_pkg::K_ONE;
            r_vld   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_stiff <= i_cfg_data;
            end
            if (w_en) begin
                r_vld <= {r_vld[dcp_pkg::PIPE_STAGES-2:0], i_valid};
            end
        end
    end

    // stage A: differences, magnitudes, mass products, mass sum, zero-mass status
    dcp_pkg::t_side n_a, r_a;
    always_comb begin
        logic [dcp_pkg::MAG_W-1:0]   d;
        logic [dcp_pkg::STIFF_W-1:0] kc;
        n_a      = '0;
        n_a.p1   = {i_word.first_z, i_word.first_y, i_word.first_x};
        n_a.p2   = {i_word.second_z, i_word.second_y, i_word.second_x};
        n_a.idx1 = i_word.first_index;
        n_a.idx2 = i_word.second_index;
        n_a.rest = i_word.rest_length;
        for (int i = 0; i < 3; i++) begin
            d = {n_a.p1[i][dcp_pkg::POS_W-1], n_a.p1[i]}
              - {n_a.p2[i][dcp_pkg::POS_W-1], n_a.p2[i]};
            n_a.neg[i] = d[dcp_pkg::MAG_W-1];
            n_a.m[i]   = d[dcp_pkg::MAG_W-1] ? -d : d;
        end
        kc       = (r_stiff > dcp_pkg::K_ONE) ? dcp_pkg::K_ONE : r_stiff;
        n_a.nf1  = {{dcp_pkg::STIFF_W{1'b0}}, i_word.first_inv_mass}
                 * {{dcp_pkg::MASS_W{1'b0}}, kc};
        n_a.nf2  = {{dcp_pkg::STIFF_W{1'b0}}, i_word.second_inv_mass}
                 * {{dcp_pkg::MASS_W{1'b0}}, kc};
        n_a.wsum = {1'b0, i_word.first_inv_mass} + {1'b0, i_word.second_inv_mass};
        n_a.status = (n_a.wsum == '0) ? dcp_pkg::ST_ZERO_MASS : dcp_pkg::ST_APPLIED;
    end

    // stage B: squares; stage C: sum and coincidence check
    dcp_pkg::t_side            r_b, r_c, n_c;
    logic [2:0][dcp_pkg::SQ_W-1:0] r_b_sq;
    logic [dcp_pkg::SQ_W-1:0]  r_c_s, n_c_s;

    always_comb begin
        n_c_s = r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        n_c   = r_b;
        if (r_b.status == dcp_pkg::ST_APPLIED && n_c_s == '0) begin
            n_c.status = dcp_pkg::ST_COINCIDENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= n_a;
            r_b <= r_a;
            for (int i = 0; i < 3; i++) begin
                r_b_sq[i] <= dcp_pkg::t_sq'(r_a.m[i]) * dcp_pkg::t_sq'(r_a.m[i]);
            end
            r_c   <= n_c;
            r_c_s <= n_c_s;
        end
    end

    // square root with side data alongside
    logic [dcp_pkg::ROOT_W-1:0] w_root;
    dcp_pkg::t_side             r_sq_side [dcp_pkg::SQ_STEPS];

    dcp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_c_s),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0] <= r_c;
            for (int j = 1; j < dcp_pkg::SQ_STEPS; j++) begin
                r_sq_side[j] <= r_sq_side[j-1];
            end
        end
    end

    // stage D: length and error
    dcp_pkg::t_side             r_d;
    logic [dcp_pkg::ROOT_W-1:0] r_d_len;
    logic [dcp_pkg::ERR_W-1:0]  r_d_err;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d     <= r_sq_side[dcp_pkg::SQ_STEPS-1];
            r_d_len <= w_root;
            r_d_err <= {1'b0, w_root}
                     - dcp_pkg::t_err'(r_sq_side[dcp_pkg::SQ_STEPS-1].rest);
        end
    end

    // dividers: unit vector per axis, mass shares
    logic [2:0][dcp_pkg::DIV_STEPS-1:0] w_u;
    logic [dcp_pkg::DIV_STEPS-1:0]      w_f1, w_f2;
    dcp_pkg::t_side                     r_dv_side [dcp_pkg::DIV_STEPS];
    logic [dcp_pkg::ERR_W-1:0]          r_dv_err  [dcp_pkg::DIV_STEPS];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_unit
            dcp_div u_div_unit (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num ({r_d.m[g], {dcp_pkg::UNIT_SH{1'b0}}}),
                .i_den (dcp_pkg::t_div_den'(r_d_len)),
                .o_quo (w_u[g])
            );
        end
    endgenerate

    dcp_div u_div_f1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (dcp_pkg::t_div_num'(r_d.nf1)),
        .i_den (dcp_pkg::t_div_den'(r_d.wsum)),
        .o_quo (w_f1)
    );

    dcp_div u_div_f2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (dcp_pkg::t_div_num'(r_d.nf2)),
        .i_den (dcp_pkg::t_div_den'(r_d.wsum)),
        .o_quo (w_f2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_side[0] <= r_d;
            r_dv_err[0]  <= r_d_err;
            for (int j = 1; j < dcp_pkg::DIV_STEPS; j++) begin
                r_dv_side[j] <= r_dv_side[j-1];
                r_dv_err[j]  <= r_dv_err[j-1];
            end
        end
    end

    // stage E: |err| * share; stage F: partial products; stage G: magnitude
    dcp_pkg::t_side                       r_e, r_f, r_g;
    logic [2:0][dcp_pkg::DIV_STEPS-1:0]   r_e_u;
    logic [1:0][dcp_pkg::A_W-1:0]         r_e_a;
    logic [2:0]                           r_e_sg, r_f_sg, r_g_sg;
    logic [1:0][2:0][dcp_pkg::PL_W-1:0]   r_f_pl;
    logic [1:0][2:0][dcp_pkg::PH_W-1:0]   r_f_ph;
    logic [1:0][2:0][dcp_pkg::CMAG_W-1:0] r_g_mag;
    logic [dcp_pkg::ERR_W-1:0]            w_err, w_me;
    logic                                 w_eneg;
    dcp_pkg::t_full                       w_full [2][3];

    assign w_err  = r_dv_err[dcp_pkg::DIV_STEPS-1];
    assign w_eneg = w_err[dcp_pkg::ERR_W-1];
    assign w_me   = w_eneg ? -w_err : w_err;

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            for (int i = 0; i < 3; i++) begin
                w_full[p][i] = {r_f_ph[p][i], {dcp_pkg::A_LO_W{1'b0}}}
                             + dcp_pkg::t_full'(r_f_pl[p][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e      <= r_dv_side[dcp_pkg::DIV_STEPS-1];
            r_e_u    <= w_u;
            r_e_a[0] <= dcp_pkg::t_a'(w_me) * dcp_pkg::t_a'(w_f1[dcp_pkg::SHARE_W-1:0]);
            r_e_a[1] <= dcp_pkg::t_a'(w_me) * dcp_pkg::t_a'(w_f2[dcp_pkg::SHARE_W-1:0]);
            r_e_sg   <= r_dv_side[dcp_pkg::DIV_STEPS-1].neg ^ {3{w_eneg}};

            r_f    <= r_e;
            r_f_sg <= r_e_sg;
            for (int p = 0; p < 2; p++) begin
                for (int i = 0; i < 3; i++) begin
                    r_f_pl[p][i] <= {{dcp_pkg::DIV_STEPS{1'b0}},
                                     r_e_a[p][dcp_pkg::A_LO_W-1:0]}
                                  * {{dcp_pkg::A_LO_W{1'b0}}, r_e_u[i]};
                    r_f_ph[p][i] <= {{dcp_pkg::DIV_STEPS{1'b0}},
                                     r_e_a[p][dcp_pkg::A_W-1:dcp_pkg::A_LO_W]}
                                  * {{dcp_pkg::A_HI_W{1'b0}}, r_e_u[i]};
                end
            end

            r_g    <= r_f;
            r_g_sg <= r_f_sg;
            for (int p = 0; p < 2; p++) begin
                for (int i = 0; i < 3; i++) begin
                    r_g_mag[p][i] <= w_full[p][i][dcp_pkg::FULL_W-1:dcp_pkg::CORR_SH];
                end
            end
        end
    end

    // stage H: apply, saturate, output register
    dcp_pkg::t_out_word n_out, r_out;
    always_comb begin
        logic [2:0][dcp_pkg::POS_W-1:0] q1, q2;
        dcp_pkg::t_acc a1, a2, mg;
        for (int i = 0; i < 3; i++) begin
            a1 = dcp_pkg::t_acc'($signed(r_g.p1[i]));
            a2 = dcp_pkg::t_acc'($signed(r_g.p2[i]));
            mg = dcp_pkg::t_acc'(r_g_mag[0][i]);
            q1[i] = dcp_pkg::sat32(r_g_sg[i] ? a1 + mg : a1 - mg);
            mg = dcp_pkg::t_acc'(r_g_mag[1][i]);
            q2[i] = dcp_pkg::sat32(r_g_sg[i] ? a2 - mg : a2 + mg);
            if (r_g.status != dcp_pkg::ST_APPLIED) begin
                q1[i] = r_g.p1[i];
                q2[i] = r_g.p2[i];
            end
        end
        n_out.new_first_x      = q1[0];
        n_out.new_first_y      = q1[1];
        n_out.new_first_z      = q1[2];
        n_out.new_second_x     = q2[0];
        n_out.new_second_y     = q2[1];
        n_out.new_second_z     = q2[2];
        n_out.out_first_index  = r_g.idx1;
        n_out.out_second_index = r_g.idx2;
        n_out.status           = r_g.status;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_word = r_out;

endmodule

### sv/dcp_checker.sv
module dcp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_ready,
    input  logic               o_valid,
    input  logic               i_ready,
    input  dcp_pkg::t_out_word o_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word))
        else $error("output word changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.status == dcp_pkg::ST_APPLIED ||
                     o_word.status == dcp_pkg::ST_ZERO_MASS ||
                     o_word.status == dcp_pkg::ST_COINCIDENT))
        else $error("bad status code");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

endmodule

bind distance_constraint_projection dcp_checker u_dcp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_word  (o_word)
);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY   = 72;
    localparam int WD_LIMIT  = 20000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    dcp_pkg::t_in_word            i_word;
    logic                         o_valid;
    logic                         i_ready;
    dcp_pkg::t_out_word           o_word;
    logic                         i_cfg_we;
    logic [dcp_pkg::STIFF_W-1:0]  i_cfg_data;

    distance_constraint_projection i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    dcp_pkg::t_in_word            pending_words[$];
    dcp_pkg::t_out_word           projected_words[$];
    logic [dcp_pkg::STIFF_W-1:0]  stiffness;
    int                           error_count;
    int                           idle_cycles;
    bit                           no_idle;
    bit                           hold_send;
    bit                           stim_done;
    bit                           accepted_in = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [127:0] isqrt(input logic [127:0] s);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [127:0] shift_move(input logic signed [127:0] err,
            input logic [127:0] share, input logic signed [127:0] unit);
        logic [127:0] me;
        logic [127:0] mu;
        logic [127:0] mag;
        me  = err < 0 ? -err : err;
        mu  = unit < 0 ? -unit : unit;
        mag = (me * share * mu) >> 46;
        return ((err < 0) != (unit < 0)) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [dcp_pkg::POS_W-1:0] clamp(input logic signed [127:0] v);
        if (v > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (v < -128'sh80000000) return 32'h80000000;
        return v[dcp_pkg::POS_W-1:0];
    endfunction

    function automatic dcp_pkg::t_out_word project(input dcp_pkg::t_in_word w);
        dcp_pkg::t_out_word          r;
        logic signed [127:0]         p1[3];
        logic signed [127:0]         p2[3];
        logic signed [127:0]         d[3];
        logic [127:0]                s;
        logic [127:0]                len;
        logic [127:0]                k;
        logic [127:0]                wsum;
        logic [127:0]                f1;
        logic [127:0]                f2;
        logic [127:0]                m;
        logic signed [127:0]         err;
        logic signed [127:0]         u;
        logic [dcp_pkg::POS_W-1:0]   n1[3];
        logic [dcp_pkg::POS_W-1:0]   n2[3];
        p1[0] = w.first_x;  p1[1] = w.first_y;  p1[2] = w.first_z;
        p2[0] = w.second_x; p2[1] = w.second_y; p2[2] = w.second_z;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            d[i]  = p1[i] - p2[i];
            n1[i] = p1[i][dcp_pkg::POS_W-1:0];
            n2[i] = p2[i][dcp_pkg::POS_W-1:0];
            s     = s + d[i] * d[i];
        end
        wsum = 128'(w.first_inv_mass) + 128'(w.second_inv_mass);
        r.out_first_index  = w.first_index;
        r.out_second_index = w.second_index;
        if (wsum == 0) begin
            r.status = dcp_pkg::ST_ZERO_MASS;
        end else if (s == 0) begin
            r.status = dcp_pkg::ST_COINCIDENT;
        end else begin
            r.status = dcp_pkg::ST_APPLIED;
            k   = stiffness > dcp_pkg::K_ONE ? 128'(dcp_pkg::K_ONE) : 128'(stiffness);
            len = isqrt(s);
            err = $signed(len) - $signed(128'(w.rest_length));
            f1  = (128'(w.first_inv_mass) * k) / wsum;
            f2  = (128'(w.second_inv_mass) * k) / wsum;
            for (int i = 0; i < 3; i++) begin
                m = d[i] < 0 ? -d[i] : d[i];
                u = $signed((m << 30) / len);
                if (d[i] < 0) u = -u;
                n1[i] = clamp(p1[i] - shift_move(err, f1, u));
                n2[i] = clamp(p2[i] + shift_move(err, f2, u));
            end
        end
        r.new_first_x  = n1[0]; r.new_first_y  = n1[1]; r.new_first_z  = n1[2];
        r.new_second_x = n2[0]; r.new_second_y = n2[1]; r.new_second_z = n2[2];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
            input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic dcp_pkg::t_in_word rand_word();
        dcp_pkg::t_in_word w;
        w.first_x  = rand_pos(); w.first_y  = rand_pos(); w.first_z  = rand_pos();
        if ($urandom_range(0, 9) == 0) begin
            w.second_x = w.first_x; w.second_y = w.first_y; w.second_z = w.first_z;
        end else begin
            w.second_x = rand_pos(); w.second_y = rand_pos(); w.second_z = rand_pos();
        end
        w.first_inv_mass  = ($urandom_range(0, 7) == 0) ? 24'd0 : 24'($urandom);
        w.second_inv_mass = ($urandom_range(0, 7) == 0) ? 24'd0 : 24'($urandom);
        w.rest_length     = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 32'h40000))
                                                        : 31'($urandom);
        w.first_index     = 16'($urandom);
        w.second_index    = 16'($urandom);
        return w;
    endfunction

    task automatic drain();
        wait (pending_words.size() == 0 && projected_words.size() == 0 && !i_valid);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_stiffness(input logic [dcp_pkg::STIFF_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || accepted_in) begin
            if (pending_words.size() > 0 && !hold_send
                    && (no_idle || $urandom_range(0, 99) >= 13)) begin
                i_word  <= pending_words.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_idle || $urandom_range(0, 99) >= 13;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        dcp_pkg::t_out_word want;
        accepted_in <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                projected_words.push_back(project(i_word));
            end
            if (o_valid && i_ready) begin
                if (projected_words.size() == 0) begin
                    report_mismatch("unexpected word", 32'd0, 32'd0);
                end else begin
                    want = projected_words.pop_front();
                    if (o_word.new_first_x !== want.new_first_x)
                        report_mismatch("new_first_x", o_word.new_first_x, want.new_first_x);
                    if (o_word.new_first_y !== want.new_first_y)
                        report_mismatch("new_first_y", o_word.new_first_y, want.new_first_y);
                    if (o_word.new_first_z !== want.new_first_z)
                        report_mismatch("new_first_z", o_word.new_first_z, want.new_first_z);
                    if (o_word.new_second_x !== want.new_second_x)
                        report_mismatch("new_second_x", o_word.new_second_x,
                                        want.new_second_x);
                    if (o_word.new_second_y !== want.new_second_y)
                        report_mismatch("new_second_y", o_word.new_second_y,
                                        want.new_second_y);
                    if (o_word.new_second_z !== want.new_second_z)
                        report_mismatch("new_second_z", o_word.new_second_z,
                                        want.new_second_z);
                    if (o_word.out_first_index !== want.out_first_index)
                        report_mismatch("out_first_index", o_word.out_first_index,
                                        want.out_first_index);
                    if (o_word.out_second_index !== want.out_second_index)
                        report_mismatch("out_second_index", o_word.out_second_index,
                                        want.out_second_index);
                    if (o_word.status !== want.status)
                        report_mismatch("status", o_word.status, want.status);
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WD_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [dcp_pkg::STIFF_W-1:0] settings[5];
        dcp_pkg::t_in_word           w;
        settings[0] = dcp_pkg::K_ONE;
        settings[1] = 17'd0;
        settings[2] = 17'h1FFFF;
        settings[3] = 17'h08000;
        settings[4] = 17'h00001;
        error_count = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        hold_send   = 1'b0;
        stim_done   = 1'b0;
        stiffness   = dcp_pkg::K_ONE;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_word      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words at reset stiffness
        w = '0;
        w.first_inv_mass = 24'h010000;
        pending_words.push_back(w);
        w.first_inv_mass = 24'd0;
        w.first_x = 32'h00010000;
        pending_words.push_back(w);
        w = '0;
        w.first_x = 32'h7FFFFFFF; w.first_y = 32'h7FFFFFFF; w.first_z = 32'h7FFFFFFF;
        w.second_x = 32'h80000000; w.second_y = 32'h80000000; w.second_z = 32'h80000000;
        w.first_inv_mass = 24'hFFFFFF; w.second_inv_mass = 24'hFFFFFF;
        w.first_index = 16'hFFFF; w.second_index = 16'hFFFF;
        pending_words.push_back(w);
        w.rest_length = 31'h7FFFFFFF;
        pending_words.push_back(w);
        w.second_inv_mass = 24'd0;
        pending_words.push_back(w);
        w = '0;
        w.first_x = 32'h00020000; w.second_inv_mass = 24'h000001;
        w.rest_length = 31'h00010000;
        pending_words.push_back(w);
        w.first_x = 32'h80000000; w.second_x = 32'h7FFFFFFF;
        w.first_y = 32'hFFFFFFFF; w.second_z = 32'h00000001;
        pending_words.push_back(w);
        w.second_x = w.first_x; w.second_y = w.first_y; w.second_z = w.first_z;
        pending_words.push_back(w);
        for (int i = 0; i < 8; i++) pending_words.push_back(rand_word());
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            if (phase < 5) begin
                write_stiffness(settings[phase]);
                stiffness = settings[phase];
            end else begin
                stiffness = 17'($urandom_range(0, 17'h1FFFF));
                write_stiffness(stiffness);
            end
            no_idle = (phase == 3);
            for (int i = 0; i < 80; i++) begin
                pending_words.push_back(rand_word());
                if (phase == 6 && i == 40) begin
                    wait (pending_words.size() == 0);
                    hold_send = 1'b1;
                    wait (projected_words.size() == 0 && !i_valid);
                    hold_send = 1'b0;
                end
            end
            drain();
        end
        stim_done = 1'b1;

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
